@@ rtl/core/cvb_pkg.sv @@
// cvb_pkg: shared constants and types for the compound voltage block.
// Holds limit widths, reset limits, config register indexes and the limits struct.
// No dependencies.
package cvb_pkg;

  // Sample width default (phasor parts, LSB 1/64 V)
  localparam int DEF_SAMPLE_WIDTH = 16;

  // Limit registers: 15-bit unsigned, kept squared
  localparam int LIMIT_WIDTH = 15;
  localparam int LIM2_WIDTH  = 2 * LIMIT_WIDTH;

  // Config port
  localparam int CFG_IDX_WIDTH = 2;
  localparam logic [CFG_IDX_WIDTH-1:0] IDX_UNDER_VOLTAGE = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] IDX_ZERO_SEQ      = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] IDX_NEG_SEQ       = 2'd2;

  // Reset limits: 0.7, 0.06 and 0.04 of 220 V at 1/64 V
  localparam logic [LIMIT_WIDTH-1:0] RST_UNDER_VOLTAGE = 15'd9856;
  localparam logic [LIMIT_WIDTH-1:0] RST_ZERO_SEQ      = 15'd845;
  localparam logic [LIMIT_WIDTH-1:0] RST_NEG_SEQ       = 15'd563;

  localparam logic [LIM2_WIDTH-1:0] RST_UNDER_VOLTAGE2 =
    LIM2_WIDTH'(RST_UNDER_VOLTAGE) * LIM2_WIDTH'(RST_UNDER_VOLTAGE);
  localparam logic [LIM2_WIDTH-1:0] RST_ZERO_SEQ2 =
    LIM2_WIDTH'(RST_ZERO_SEQ) * LIM2_WIDTH'(RST_ZERO_SEQ);
  localparam logic [LIM2_WIDTH-1:0] RST_NEG_SEQ2 =
    LIM2_WIDTH'(RST_NEG_SEQ) * LIM2_WIDTH'(RST_NEG_SEQ);

  // sqrt(3)/2 in Q16 and the round-half-up offset
  localparam logic [16:0] HALF_SQRT3_Q16 = 17'd56756;
  localparam int          ROUND_HALF_Q16 = 32768;

  // Squared limits handed to the detector
  typedef struct packed {
    logic [LIM2_WIDTH-1:0] uv2;
    logic [LIM2_WIDTH-1:0] zs2;
    logic [LIM2_WIDTH-1:0] ns2;
  } cvb_lim_t;

endpackage

@@ rtl/core/cvb_limits.sv @@
// cvb_limits: configuration registers, stored as squared limits.
// Depends on cvb_pkg.
module cvb_limits (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [cvb_pkg::CFG_IDX_WIDTH-1:0]      cfg_idx_i,
  input  logic [cvb_pkg::LIMIT_WIDTH-1:0]        cfg_wdata_i,
  output cvb_pkg::cvb_lim_t                      lim_o
);

  cvb_pkg::cvb_lim_t             lim_q, lim_d;
  logic [cvb_pkg::LIM2_WIDTH-1:0] sq_wdata;

  // Square the written limit once, at write time
  assign sq_wdata = cvb_pkg::LIM2_WIDTH'(cfg_wdata_i) * cvb_pkg::LIM2_WIDTH'(cfg_wdata_i);

  always_comb begin
    lim_d = lim_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cvb_pkg::IDX_UNDER_VOLTAGE: lim_d.uv2 = sq_wdata;
        cvb_pkg::IDX_ZERO_SEQ:      lim_d.zs2 = sq_wdata;
        cvb_pkg::IDX_NEG_SEQ:       lim_d.ns2 = sq_wdata;
        default:                    lim_d = lim_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.uv2 <= cvb_pkg::RST_UNDER_VOLTAGE2;
      lim_q.zs2 <= cvb_pkg::RST_ZERO_SEQ2;
      lim_q.ns2 <= cvb_pkg::RST_NEG_SEQ2;
    end else begin
      lim_q <= lim_d;
    end
  end

  assign lim_o = lim_q;

  a_uv_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == cvb_pkg::IDX_UNDER_VOLTAGE |=> lim_q.uv2 == $past(sq_wdata))
    else $error("under-voltage limit not stored squared");
  a_ns_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == cvb_pkg::IDX_NEG_SEQ |=> lim_q.ns2 == $past(sq_wdata)
      && $stable(lim_q.uv2) && $stable(lim_q.zs2))
    else $error("neg-seq write disturbed another limit");
  a_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> $stable(lim_q))
    else $error("limits changed without a write");

endmodule

@@ rtl/core/cvb_phasor.sv @@
// cvb_phasor: three-stage phasor datapath: sums, products, magnitudes and
// rounded negative-sequence parts. Depends on cvb_pkg.
module cvb_phasor #(
  parameter int SAMPLE_WIDTH = cvb_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            up_valid_i,
  output logic                            up_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]  ar_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  ai_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  br_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  bi_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  cr_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  ci_i,
  output logic                            dn_valid_o,
  input  logic                            dn_ready_i,
  output logic [2*SAMPLE_WIDTH:0]         mag_a_o,
  output logic [2*SAMPLE_WIDTH:0]         mag_b_o,
  output logic [2*SAMPLE_WIDTH:0]         mag_c_o,
  output logic [2*SAMPLE_WIDTH+4:0]       mag_z_o,
  output logic signed [SAMPLE_WIDTH+3:0]  re_o,
  output logic signed [SAMPLE_WIDTH+3:0]  im_o
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int SW  = W + 2;       // zero-seq sum
  localparam int DW  = W + 1;       // pair sums and differences
  localparam int TW  = W + 2;       // 2a - (b + c)
  localparam int PW  = 2 * W;       // phase part squared
  localparam int ZW  = 2 * SW;      // zero-seq part squared
  localparam int KW  = DW + 18;     // K times a difference
  localparam int XW  = W + 20;      // Q16 negative-seq part
  localparam int RW  = XW - 16;     // rounded negative-seq part
  localparam int MPW = 2 * W + 1;
  localparam int MZW = 2 * W + 5;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  // Stage 1: pair and zero-seq sums
  logic signed [W-1:0]  s1_ar_q, s1_ai_q, s1_br_q, s1_bi_q, s1_cr_q, s1_ci_q;
  logic signed [SW-1:0] s1_s0r_q, s1_s0i_q, s1_s0r_d, s1_s0i_d;
  logic signed [DW-1:0] s1_p_q, s1_u_q, s1_q_q, s1_v_q;
  logic signed [DW-1:0] s1_p_d, s1_u_d, s1_q_d, s1_v_d;

  // Stage 2: products
  logic signed [PW-1:0] s2_sq_ar_q, s2_sq_ai_q, s2_sq_br_q, s2_sq_bi_q, s2_sq_cr_q, s2_sq_ci_q;
  logic signed [PW-1:0] s2_sq_ar_d, s2_sq_ai_d, s2_sq_br_d, s2_sq_bi_d, s2_sq_cr_d, s2_sq_ci_d;
  logic signed [ZW-1:0] s2_sq_s0r_q, s2_sq_s0i_q, s2_sq_s0r_d, s2_sq_s0i_d;
  logic signed [KW-1:0] s2_kq_q, s2_kv_q, s2_kq_d, s2_kv_d;
  logic signed [TW-1:0] s2_tr_q, s2_ti_q, s2_tr_d, s2_ti_d;

  // Stage 3: magnitudes and rounded parts
  logic [MPW-1:0]       s3_mag_a_q, s3_mag_b_q, s3_mag_c_q, s3_mag_a_d, s3_mag_b_d, s3_mag_c_d;
  logic [MZW-1:0]       s3_mag_z_q, s3_mag_z_d;
  logic signed [RW-1:0] s3_re_q, s3_im_q, s3_re_d, s3_im_d;
  logic signed [XW-1:0] re_pre, im_pre;

  // Per-stage ready: a stage loads when empty or when its successor loads
  assign rdy3       = !v3_q || dn_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign up_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= up_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage 1 logic
  always_comb begin
    s1_s0r_d = SW'(ar_i) + SW'(br_i) + SW'(cr_i);
    s1_s0i_d = SW'(ai_i) + SW'(bi_i) + SW'(ci_i);
    s1_p_d   = DW'(br_i) + DW'(cr_i);
    s1_u_d   = DW'(bi_i) + DW'(ci_i);
    s1_q_d   = DW'(bi_i) - DW'(ci_i);
    s1_v_d   = DW'(cr_i) - DW'(br_i);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && up_valid_i) begin
      s1_ar_q  <= ar_i;
      s1_ai_q  <= ai_i;
      s1_br_q  <= br_i;
      s1_bi_q  <= bi_i;
      s1_cr_q  <= cr_i;
      s1_ci_q  <= ci_i;
      s1_s0r_q <= s1_s0r_d;
      s1_s0i_q <= s1_s0i_d;
      s1_p_q   <= s1_p_d;
      s1_u_q   <= s1_u_d;
      s1_q_q   <= s1_q_d;
      s1_v_q   <= s1_v_d;
    end
  end

  // Stage 2 logic: squares, K products, 2a - (b + c)
  always_comb begin
    s2_sq_ar_d  = PW'(s1_ar_q) * PW'(s1_ar_q);
    s2_sq_ai_d  = PW'(s1_ai_q) * PW'(s1_ai_q);
    s2_sq_br_d  = PW'(s1_br_q) * PW'(s1_br_q);
    s2_sq_bi_d  = PW'(s1_bi_q) * PW'(s1_bi_q);
    s2_sq_cr_d  = PW'(s1_cr_q) * PW'(s1_cr_q);
    s2_sq_ci_d  = PW'(s1_ci_q) * PW'(s1_ci_q);
    s2_sq_s0r_d = ZW'(s1_s0r_q) * ZW'(s1_s0r_q);
    s2_sq_s0i_d = ZW'(s1_s0i_q) * ZW'(s1_s0i_q);
    s2_kq_d     = KW'($signed({1'b0, cvb_pkg::HALF_SQRT3_Q16})) * KW'(s1_q_q);
    s2_kv_d     = KW'($signed({1'b0, cvb_pkg::HALF_SQRT3_Q16})) * KW'(s1_v_q);
    s2_tr_d     = TW'(s1_ar_q) + TW'(s1_ar_q) - TW'(s1_p_q);
    s2_ti_d     = TW'(s1_ai_q) + TW'(s1_ai_q) - TW'(s1_u_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_sq_ar_q  <= s2_sq_ar_d;
      s2_sq_ai_q  <= s2_sq_ai_d;
      s2_sq_br_q  <= s2_sq_br_d;
      s2_sq_bi_q  <= s2_sq_bi_d;
      s2_sq_cr_q  <= s2_sq_cr_d;
      s2_sq_ci_q  <= s2_sq_ci_d;
      s2_sq_s0r_q <= s2_sq_s0r_d;
      s2_sq_s0i_q <= s2_sq_s0i_d;
      s2_kq_q     <= s2_kq_d;
      s2_kv_q     <= s2_kv_d;
      s2_tr_q     <= s2_tr_d;
      s2_ti_q     <= s2_ti_d;
    end
  end

  // Stage 3 logic: sums of squares; Q16 parts rounded half up
  always_comb begin
    s3_mag_a_d = MPW'($unsigned(s2_sq_ar_q)) + MPW'($unsigned(s2_sq_ai_q));
    s3_mag_b_d = MPW'($unsigned(s2_sq_br_q)) + MPW'($unsigned(s2_sq_bi_q));
    s3_mag_c_d = MPW'($unsigned(s2_sq_cr_q)) + MPW'($unsigned(s2_sq_ci_q));
    s3_mag_z_d = MZW'($unsigned(s2_sq_s0r_q)) + MZW'($unsigned(s2_sq_s0i_q));
    re_pre     = (XW'(s2_tr_q) <<< 15) + XW'(s2_kq_q) + XW'(cvb_pkg::ROUND_HALF_Q16);
    im_pre     = (XW'(s2_ti_q) <<< 15) + XW'(s2_kv_q) + XW'(cvb_pkg::ROUND_HALF_Q16);
    s3_re_d    = $signed(re_pre[XW-1:16]);
    s3_im_d    = $signed(im_pre[XW-1:16]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      s3_mag_a_q <= s3_mag_a_d;
      s3_mag_b_q <= s3_mag_b_d;
      s3_mag_c_q <= s3_mag_c_d;
      s3_mag_z_q <= s3_mag_z_d;
      s3_re_q    <= s3_re_d;
      s3_im_q    <= s3_im_d;
    end
  end

  assign dn_valid_o = v3_q;
  assign mag_a_o    = s3_mag_a_q;
  assign mag_b_o    = s3_mag_b_q;
  assign mag_c_o    = s3_mag_c_q;
  assign mag_z_o    = s3_mag_z_q;
  assign re_o       = s3_re_q;
  assign im_o       = s3_im_q;

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    up_valid_i && rdy1 |=> v1_q)
    else $error("accepted transaction missing in stage 1");
  a_hold2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !rdy2 |=> v2_q && $stable(s2_kq_q))
    else $error("stage 2 lost data under stall");
  a_move3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && rdy3 |=> v3_q)
    else $error("stage 2 did not advance into stage 3");

endmodule

@@ rtl/core/cvb_detect.sv @@
// cvb_detect: two-stage compare: phase and zero-seq checks with neg-seq
// squares, then neg-seq check and output register. Depends on cvb_pkg.
module cvb_detect #(
  parameter int SAMPLE_WIDTH = cvb_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cvb_pkg::cvb_lim_t               lim_i,
  input  logic                            up_valid_i,
  output logic                            up_ready_o,
  input  logic [2*SAMPLE_WIDTH:0]         mag_a_i,
  input  logic [2*SAMPLE_WIDTH:0]         mag_b_i,
  input  logic [2*SAMPLE_WIDTH:0]         mag_c_i,
  input  logic [2*SAMPLE_WIDTH+4:0]       mag_z_i,
  input  logic signed [SAMPLE_WIDTH+3:0]  re_i,
  input  logic signed [SAMPLE_WIDTH+3:0]  im_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            voltage_normal_o,
  output logic                            phase_low_o,
  output logic                            zero_seq_high_o,
  output logic                            neg_seq_high_o
);

  localparam int RW  = SAMPLE_WIDTH + 4;
  localparam int QW  = 2 * RW;
  localparam int NW  = QW + 1;
  localparam int CW  = (NW > cvb_pkg::LIM2_WIDTH) ? NW : cvb_pkg::LIM2_WIDTH;

  logic v4_q, v5_q, rdy4, rdy5;

  logic                 s4_low_q, s4_zhigh_q, s4_low_d, s4_zhigh_d;
  logic signed [QW-1:0] s4_re2_q, s4_im2_q, s4_re2_d, s4_im2_d;

  logic          s5_low_q, s5_zhigh_q, s5_nhigh_q, s5_normal_q;
  logic          s5_nhigh_d;
  logic [NW-1:0] mag_n;

  assign rdy5       = !v5_q || out_ready_i;
  assign rdy4       = !v4_q || rdy5;
  assign up_ready_o = rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= up_valid_i;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // Stage 4: phase and zero-seq compares, neg-seq squares
  always_comb begin
    s4_low_d   = (CW'(mag_a_i) <= CW'(lim_i.uv2)) || (CW'(mag_b_i) <= CW'(lim_i.uv2))
              || (CW'(mag_c_i) <= CW'(lim_i.uv2));
    s4_zhigh_d = CW'(mag_z_i) >= CW'(lim_i.zs2);
    s4_re2_d   = QW'(re_i) * QW'(re_i);
    s4_im2_d   = QW'(im_i) * QW'(im_i);
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && up_valid_i) begin
      s4_low_q   <= s4_low_d;
      s4_zhigh_q <= s4_zhigh_d;
      s4_re2_q   <= s4_re2_d;
      s4_im2_q   <= s4_im2_d;
    end
  end

  // Stage 5: neg-seq magnitude compare and result register
  assign mag_n      = NW'($unsigned(s4_re2_q)) + NW'($unsigned(s4_im2_q));
  assign s5_nhigh_d = CW'(mag_n) >= CW'(lim_i.ns2);

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      s5_low_q    <= s4_low_q;
      s5_zhigh_q  <= s4_zhigh_q;
      s5_nhigh_q  <= s5_nhigh_d;
      s5_normal_q <= !(s4_low_q || s4_zhigh_q || s5_nhigh_d);
    end
  end

  assign out_valid_o      = v5_q;
  assign voltage_normal_o = s5_normal_q;
  assign phase_low_o      = s5_low_q;
  assign zero_seq_high_o  = s5_zhigh_q;
  assign neg_seq_high_o   = s5_nhigh_q;

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    up_valid_i && rdy4 |=> v4_q)
    else $error("transaction missing in stage 4");
  a_hold4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !rdy5 |=> v4_q && $stable(s4_re2_q))
    else $error("stage 4 lost data under stall");
  a_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> voltage_normal_o == !(phase_low_o || zero_seq_high_o || neg_seq_high_o))
    else $error("voltage_normal disagrees with cause bits");

endmodule

@@ rtl/core/compound_voltage_block_top.sv @@
// compound_voltage_block_top: compound voltage blocking element for one bus.
// Depends on cvb_pkg, cvb_limits, cvb_phasor, cvb_detect.
//
//  Channel  Signals                                  Direction  Handshake
//  cfg      cfg_we_i, cfg_idx_i, cfg_wdata_i         in         write on cfg_we_i, no wait
//  in       in_valid_i/in_ready_o, phase_*_i         in         valid/ready
//  out      out_valid_o/out_ready_i, result bits     out        valid/ready
//
// One transaction per cycle sustained while the output is not stalled; the path from
// input accept to output valid runs through 3 phasor stages and 2 compare stages.
// Each stage has its own valid bit and loads when empty or when its successor
// loads, so bubbles fill while the output stalls; nothing is dropped or repeated.
// Reset (rst_ni low, async) empties the pipeline and restores the default limits.
module compound_voltage_block_top #(
  parameter int SAMPLE_WIDTH = cvb_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cvb_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx_i,
  input  logic [cvb_pkg::LIMIT_WIDTH-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      phase_a_real_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      phase_a_imag_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      phase_b_real_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      phase_b_imag_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      phase_c_real_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      phase_c_imag_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                voltage_normal_o,
  output logic                                phase_low_o,
  output logic                                zero_seq_high_o,
  output logic                                neg_seq_high_o
);

  cvb_pkg::cvb_lim_t              lim;
  logic                           mid_valid, mid_ready;
  logic [2*SAMPLE_WIDTH:0]        mag_a, mag_b, mag_c;
  logic [2*SAMPLE_WIDTH+4:0]      mag_z;
  logic signed [SAMPLE_WIDTH+3:0] neg_re, neg_im;

  // Squared limit registers
  cvb_limits u_limits (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .lim_o       (lim)
  );

  // Phasor arithmetic
  cvb_phasor #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_phasor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (in_valid_i),
    .up_ready_o (in_ready_o),
    .ar_i       (phase_a_real_i),
    .ai_i       (phase_a_imag_i),
    .br_i       (phase_b_real_i),
    .bi_i       (phase_b_imag_i),
    .cr_i       (phase_c_real_i),
    .ci_i       (phase_c_imag_i),
    .dn_valid_o (mid_valid),
    .dn_ready_i (mid_ready),
    .mag_a_o    (mag_a),
    .mag_b_o    (mag_b),
    .mag_c_o    (mag_c),
    .mag_z_o    (mag_z),
    .re_o       (neg_re),
    .im_o       (neg_im)
  );

  // Limit compares and result register
  cvb_detect #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_detect (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .lim_i            (lim),
    .up_valid_i       (mid_valid),
    .up_ready_o       (mid_ready),
    .mag_a_i          (mag_a),
    .mag_b_i          (mag_b),
    .mag_c_i          (mag_c),
    .mag_z_i          (mag_z),
    .re_i             (neg_re),
    .im_i             (neg_im),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .voltage_normal_o (voltage_normal_o),
    .phase_low_o      (phase_low_o),
    .zero_seq_high_o  (zero_seq_high_o),
    .neg_seq_high_o   (neg_seq_high_o)
  );

endmodule
